FILE: rtl/core/ps2mpt_pkg.sv
package ps2mpt_pkg;

   localparam int SIZE_BITS = 14;
   localparam int BYTE_BITS = 8;
   localparam int unsigned OVF_STEP = 255;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 14'd1024;
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 14'd768;

   typedef enum logic [0:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_X      = 2'd1,
      PHASE_Y      = 2'd2
   } phase_type;

   typedef struct packed {
      logic y_ovf;
      logic x_ovf;
      logic y_sign;
      logic x_sign;
      logic sync;
      logic middle;
      logic right;
      logic left;
   } header_type;

   typedef struct packed {
      logic sign;
      logic ovf;
      logic invert;
   } axis_ctl_type;

endpackage

FILE: rtl/core/ps2mpt_req_if.sv
interface ps2mpt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/ps2mpt_rsp_if.sv
interface ps2mpt_rsp_if #(
   parameter int COORD_BITS = 13
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic                  left_pressed;
   logic                  right_pressed;
   logic                  middle_pressed;

   modport source (
      output valid, output cursor_x, output cursor_y,
      output left_pressed, output right_pressed, output middle_pressed,
      input ready
   );
   modport sink (
      input valid, input cursor_x, input cursor_y,
      input left_pressed, input right_pressed, input middle_pressed,
      output ready
   );
endinterface

FILE: rtl/core/ps2mpt_axis.sv
module ps2mpt_axis #(
   parameter int COORD_BITS = 13
) (
   input  logic [COORD_BITS-1:0]           pos,
   input  logic [ps2mpt_pkg::BYTE_BITS-1:0] delta_byte,
   input  ps2mpt_pkg::axis_ctl_type         ctl,
   input  logic [ps2mpt_pkg::SIZE_BITS-1:0] size,
   output logic [COORD_BITS-1:0]           pos_next
);

   localparam int SW = ((COORD_BITS > ps2mpt_pkg::SIZE_BITS) ?
                        COORD_BITS : ps2mpt_pkg::SIZE_BITS) + 3;
   localparam logic [SW-1:0] POS_RANGE = {{(SW-1){1'b0}}, 1'b1} << COORD_BITS;
   localparam logic [SW-1:0] OVF_EXT = SW'(ps2mpt_pkg::OVF_STEP);

   logic [SW-1:0] delta;
   logic [SW-1:0] base;
   logic [SW-1:0] sum;
   logic [SW-1:0] size_ext;
   logic [SW-1:0] max_pos;

   always_comb begin
      delta = {{(SW-ps2mpt_pkg::BYTE_BITS){ctl.sign}}, delta_byte};
      if (ctl.ovf) begin
         delta = ctl.sign ? (delta - OVF_EXT) : (delta + OVF_EXT);
      end
      base = {{(SW-COORD_BITS){1'b0}}, pos};
      sum = ctl.invert ? (base - delta) : (base + delta);

      size_ext = {{(SW-ps2mpt_pkg::SIZE_BITS){1'b0}}, size};
      if (size == '0) begin
         max_pos = '0;
      end else if (size_ext > POS_RANGE) begin
         max_pos = POS_RANGE - {{(SW-1){1'b0}}, 1'b1};
      end else begin
         max_pos = size_ext - {{(SW-1){1'b0}}, 1'b1};
      end

      if (sum[SW-1]) begin
         pos_next = '0;
      end else if (sum > max_pos) begin
         pos_next = max_pos[COORD_BITS-1:0];
      end else begin
         pos_next = sum[COORD_BITS-1:0];
      end
   end

endmodule

FILE: rtl/core/ps2mouse_packet_tracker_top_placeholder.sv
module ps2mpt_hold #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             drain,
   input  logic [WIDTH-1:0] data_in,
   output logic             valid,
   output logic [WIDTH-1:0] data_out
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   assign valid_in = load | (valid_ff & ~drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid    = valid_ff;
   assign data_out = data_ff;

endmodule

FILE: rtl/core/ps2_mouse_packet_tracker_top.sv
// an accepted req word goes through the input register, then the result register, to its rsp word
// one req word per cycle unless rsp stalls; the rsp register refills as the old word leaves
// a result appears only on the third byte of an aligned packet; other bytes give none
// reset (synchronous, active high): first byte is dropped, phase at header, cursor at 0,0,
// screen size 1024 by 768, both registers empty
module ps2_mouse_packet_tracker_top #(
   parameter int COORD_BITS = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   ps2mpt_req_if.sink                        req_chan,
   ps2mpt_rsp_if.source                      rsp_chan,
   input  logic                              csr_wr_en,
   input  ps2mpt_pkg::csr_index_type         csr_index,
   input  logic [ps2mpt_pkg::SIZE_BITS-1:0]  csr_wr_data
);

   logic [ps2mpt_pkg::SIZE_BITS-1:0] width_ff;
   logic [ps2mpt_pkg::SIZE_BITS-1:0] height_ff;

   logic                             in_valid;
   logic [ps2mpt_pkg::BYTE_BITS-1:0] in_byte;
   logic                             req_accept;
   logic                             work_fire;
   logic                             out_free;

   logic                   drop_ff;
   logic                   drop_in;
   ps2mpt_pkg::phase_type  phase_ff;
   ps2mpt_pkg::phase_type  phase_in;
   ps2mpt_pkg::header_type header_ff;
   ps2mpt_pkg::header_type header_in;
   logic [ps2mpt_pkg::BYTE_BITS-1:0] x_byte_ff;
   logic [ps2mpt_pkg::BYTE_BITS-1:0] x_byte_in;
   logic [COORD_BITS-1:0]  pos_x_ff;
   logic [COORD_BITS-1:0]  pos_y_ff;
   logic [COORD_BITS-1:0]  pos_x_next;
   logic [COORD_BITS-1:0]  pos_y_next;
   logic                   emit;

   ps2mpt_pkg::axis_ctl_type x_ctl;
   ps2mpt_pkg::axis_ctl_type y_ctl;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [COORD_BITS-1:0] cursor_x_ff;
   logic [COORD_BITS-1:0] cursor_y_ff;
   logic [2:0]            buttons_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ps2mpt_pkg::WIDTH_RESET;
         height_ff <= ps2mpt_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ps2mpt_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wr_data;
            ps2mpt_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // input register
   assign out_free   = ~rsp_valid_ff | rsp_chan.ready;
   assign work_fire  = in_valid & out_free;
   assign req_chan.ready = ~in_valid | work_fire;
   assign req_accept = req_chan.valid & req_chan.ready;

   ps2mpt_hold #(
      .WIDTH (ps2mpt_pkg::BYTE_BITS)
   ) u_in_hold (
      .clock    (clock),
      .reset    (reset),
      .load     (req_accept),
      .drain    (work_fire),
      .data_in  (req_chan.rx_byte),
      .valid    (in_valid),
      .data_out (in_byte)
   );

   // packet phase next state
   always_comb begin
      drop_in   = drop_ff;
      phase_in  = phase_ff;
      header_in = header_ff;
      x_byte_in = x_byte_ff;
      if (work_fire) begin
         if (drop_ff) begin
            drop_in = 1'b0;
         end else begin
            case (phase_ff)
               ps2mpt_pkg::PHASE_X: begin
                  x_byte_in = in_byte;
                  phase_in  = ps2mpt_pkg::PHASE_Y;
               end
               ps2mpt_pkg::PHASE_Y: begin
                  phase_in = ps2mpt_pkg::PHASE_HEADER;
               end
               default: begin
                  if (in_byte[3]) begin
                     header_in = ps2mpt_pkg::header_type'(in_byte);
                     phase_in  = ps2mpt_pkg::PHASE_X;
                  end else begin
                     phase_in = ps2mpt_pkg::PHASE_HEADER;
                  end
               end
            endcase
         end
      end
   end

   // packet phase outputs
   always_comb begin
      emit = work_fire & ~drop_ff & (phase_ff == ps2mpt_pkg::PHASE_Y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff   <= 1'b1;
         phase_ff  <= ps2mpt_pkg::PHASE_HEADER;
         header_ff <= '0;
         x_byte_ff <= '0;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
      end else begin
         drop_ff   <= drop_in;
         phase_ff  <= phase_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
         if (emit) begin
            pos_x_ff <= pos_x_next;
            pos_y_ff <= pos_y_next;
         end
      end
   end

   assign x_ctl = '{sign: header_ff.x_sign, ovf: header_ff.x_ovf, invert: 1'b0};
   assign y_ctl = '{sign: header_ff.y_sign, ovf: header_ff.y_ovf, invert: 1'b1};

   ps2mpt_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_x (
      .pos        (pos_x_ff),
      .delta_byte (x_byte_ff),
      .ctl        (x_ctl),
      .size       (width_ff),
      .pos_next   (pos_x_next)
   );

   // screen y grows downward
   ps2mpt_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_y (
      .pos        (pos_y_ff),
      .delta_byte (in_byte),
      .ctl        (y_ctl),
      .size       (height_ff),
      .pos_next   (pos_y_next)
   );

   // result register
   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cursor_x_ff <= pos_x_next;
         cursor_y_ff <= pos_y_next;
         buttons_ff  <= {header_ff.middle, header_ff.right, header_ff.left};
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cursor_x       = cursor_x_ff;
   assign rsp_chan.cursor_y       = cursor_y_ff;
   assign rsp_chan.left_pressed   = buttons_ff[0];
   assign rsp_chan.right_pressed  = buttons_ff[1];
   assign rsp_chan.middle_pressed = buttons_ff[2];

endmodule

FILE: sim/tb_ps2_mouse_packet_tracker_top.sv
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_tracker_top;

   localparam int COORD_BITS = 13;
   localparam int POS_LIMIT  = 1 << COORD_BITS;
   localparam int LATENCY    = 2;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  left;
      logic                  right;
      logic                  middle;
   } cursor_word_type;

   class cursor_tracker;
      bit                     drop_next;
      ps2mpt_pkg::phase_type  phase;
      ps2mpt_pkg::header_type hdr;
      logic [7:0]             x_byte;
      int                     pos_x;
      int                     pos_y;
      int                     width;
      int                     height;
      cursor_word_type        cursor_q[$];
      int                     errors;

      function new();
         drop_next = 1'b1;
         phase     = ps2mpt_pkg::PHASE_HEADER;
         hdr       = '0;
         x_byte    = '0;
         pos_x     = 0;
         pos_y     = 0;
         width     = int'(ps2mpt_pkg::WIDTH_RESET);
         height    = int'(ps2mpt_pkg::HEIGHT_RESET);
         errors    = 0;
      endfunction

      function void set_size(ps2mpt_pkg::csr_index_type idx,
                             logic [ps2mpt_pkg::SIZE_BITS-1:0] v);
         if (idx == ps2mpt_pkg::CSR_SCREEN_WIDTH) begin
            width = int'(v);
         end else begin
            height = int'(v);
         end
      endfunction

      function int axis_delta(logic [7:0] b, logic neg, logic ovf);
         int d;
         d = int'(b);
         if (neg) begin
            d -= 256;
         end
         if (ovf) begin
            d += neg ? -int'(ps2mpt_pkg::OVF_STEP) : int'(ps2mpt_pkg::OVF_STEP);
         end
         return d;
      endfunction

      function int clamp_axis(int v, int size);
         int lim;
         lim = size;
         if (lim > POS_LIMIT) begin
            lim = POS_LIMIT;
         end
         if (lim == 0) begin
            lim = 1;
         end
         if (v < 0) begin
            return 0;
         end
         if (v > lim - 1) begin
            return lim - 1;
         end
         return v;
      endfunction

      // accepted rx byte
      function void note_byte(logic [7:0] b);
         cursor_word_type w;
         if (drop_next) begin
            drop_next = 1'b0;
            return;
         end
         case (phase)
            ps2mpt_pkg::PHASE_X: begin
               x_byte = b;
               phase  = ps2mpt_pkg::PHASE_Y;
            end
            ps2mpt_pkg::PHASE_Y: begin
               phase = ps2mpt_pkg::PHASE_HEADER;
               pos_x = clamp_axis(pos_x + axis_delta(x_byte, hdr.x_sign, hdr.x_ovf), width);
               pos_y = clamp_axis(pos_y - axis_delta(b, hdr.y_sign, hdr.y_ovf), height);
               w.x      = COORD_BITS'(pos_x);
               w.y      = COORD_BITS'(pos_y);
               w.left   = hdr.left;
               w.right  = hdr.right;
               w.middle = hdr.middle;
               cursor_q.push_back(w);
            end
            default: begin
               if (b[3]) begin
                  hdr   = ps2mpt_pkg::header_type'(b);
                  phase = ps2mpt_pkg::PHASE_X;
               end else begin
                  phase = ps2mpt_pkg::PHASE_HEADER;
               end
            end
         endcase
      endfunction

      function void check_result(cursor_word_type got);
         cursor_word_type exp;
         if (cursor_q.size() == 0) begin
            $error("unexpected cursor word: x=%0d y=%0d", got.x, got.y);
            errors++;
            return;
         end
         exp = cursor_q.pop_front();
         if (got.x !== exp.x) begin
            $error("cursor_x mismatch: expected %0d, actual %0d", exp.x, got.x);
            errors++;
         end
         if (got.y !== exp.y) begin
            $error("cursor_y mismatch: expected %0d, actual %0d", exp.y, got.y);
            errors++;
         end
         if (got.left !== exp.left) begin
            $error("left_pressed mismatch: expected %0b, actual %0b", exp.left, got.left);
            errors++;
         end
         if (got.right !== exp.right) begin
            $error("right_pressed mismatch: expected %0b, actual %0b", exp.right, got.right);
            errors++;
         end
         if (got.middle !== exp.middle) begin
            $error("middle_pressed mismatch: expected %0b, actual %0b",
                   exp.middle, got.middle);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_wr_en;
   ps2mpt_pkg::csr_index_type        csr_index;
   logic [ps2mpt_pkg::SIZE_BITS-1:0] csr_wr_data;

   ps2mpt_req_if                          req ();
   ps2mpt_rsp_if #(.COORD_BITS(COORD_BITS)) rsp ();

   cursor_tracker sb;
   bit            gaps_on;
   bit            stalls_on;
   int            stall_left = 0;

   ps2_mouse_packet_tracker_top #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function int pick_gap();
      int r;
      if (!gaps_on) begin
         return 0;
      end
      r = $urandom_range(0, 19);
      if (r < 12) begin
         return 0;
      end
      if (r < 19) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      cursor_word_type got;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         got.x      = rsp.cursor_x;
         got.y      = rsp.cursor_y;
         got.left   = rsp.left_pressed;
         got.right  = rsp.right_pressed;
         got.middle = rsp.middle_pressed;
         sb.check_result(got);
      end
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      req.valid   <= 1'b1;
      req.rx_byte <= b;
      @(posedge clock);
      while (req.ready !== 1'b1) begin
         @(posedge clock);
      end
      sb.note_byte(b);
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_packet(logic [7:0] hdr, logic [7:0] dx, logic [7:0] dy);
      send_byte(hdr);
      send_byte(dx);
      send_byte(dy);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (sb.cursor_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_screen(logic [ps2mpt_pkg::SIZE_BITS-1:0] w,
                               logic [ps2mpt_pkg::SIZE_BITS-1:0] h);
      csr_wr_en   <= 1'b1;
      csr_index   <= ps2mpt_pkg::CSR_SCREEN_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      sb.set_size(ps2mpt_pkg::CSR_SCREEN_WIDTH, w);
      csr_index   <= ps2mpt_pkg::CSR_SCREEN_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      sb.set_size(ps2mpt_pkg::CSR_SCREEN_HEIGHT, h);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [ps2mpt_pkg::SIZE_BITS-1:0] w;
      logic [ps2mpt_pkg::SIZE_BITS-1:0] h;
      logic [7:0]                       hdr;
      logic [7:0]                       noise;
      bit                               drift_x;
      bit                               drift_y;
      int                               n;

      sb = new();
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.rx_byte <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= ps2mpt_pkg::CSR_SCREEN_WIDTH;
      csr_wr_data <= '0;
      gaps_on    = 1'b0;
      stalls_on  = 1'b0;
      drift_x    = 1'b0;
      drift_y    = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // first byte after reset is dropped, then a misaligned byte
      send_byte(8'h08);
      send_byte(8'h07);
      send_packet(8'h0F, 8'hFF, 8'h00);
      send_packet(8'h38, 8'h00, 8'h00);
      send_packet(8'hC8, 8'hFF, 8'hFF);
      send_packet(8'hF8, 8'h00, 8'h80);
      send_packet(8'h08, 8'h7F, 8'h80);
      send_packet(8'h1A, 8'h01, 8'hFE);
      wait_idle();

      for (int setting = 0; setting < 8; setting++) begin
         case (setting)
            0: begin w = 14'd1;     h = 14'd1;     end
            1: begin w = 14'd0;     h = 14'd0;     end
            2: begin w = 14'd16383; h = 14'd16383; end
            3: begin w = 14'd8192;  h = 14'd8193;  end
            4: begin w = 14'd8191;  h = 14'd2;     end
            5: begin w = 14'd640;   h = 14'd480;   end
            6: begin
               w = 14'($urandom_range(1, 16383));
               h = 14'($urandom_range(1, 16383));
            end
            default: begin
               w = 14'($urandom_range(20, 300));
               h = 14'($urandom_range(20, 300));
            end
         endcase
         write_screen(w, h);
         gaps_on   = (setting % 3) != 1;
         stalls_on = (setting % 4) != 2;

         n = 0;
         while (n < 30) begin
            if ($urandom_range(0, 15) == 0) begin
               drift_x = 1'($urandom_range(0, 1));
               drift_y = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  noise = 8'($urandom_range(0, 255));
                  send_byte(noise);
               end
            end else begin
               hdr = 8'($urandom_range(0, 255));
               hdr[3] = 1'b1;
               if ($urandom_range(0, 3) != 0) begin
                  hdr[4] = drift_x;
                  hdr[5] = drift_y;
               end
               if ($urandom_range(0, 3) != 0) begin
                  hdr[7:6] = 2'b00;
               end
               send_packet(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               n++;
            end
            if ($urandom_range(0, 39) == 0) begin
               wait_idle();
            end
         end
         wait_idle();
      end

      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
